// ===== design/dp_link_training_controller_macros.svh =====
// Assertion helpers for the link training controller.
`ifndef DP_LINK_TRAINING_CONTROLLER_MACROS_SVH
`define DP_LINK_TRAINING_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DPLTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpltc check failed");

// Next-cycle implication, checked outside reset.
`define DPLTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpltc check failed");

`endif

// ===== design/dpltc_pkg.sv =====
`default_nettype none
package dpltc_pkg;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_CR   = 3'd1;
    localparam logic [2:0] PH_EQ   = 3'd2;
    localparam logic [2:0] PH_DONE = 3'd3;
    localparam logic [2:0] PH_FAIL = 3'd4;

    localparam logic [1:0] PAT_NONE = 2'd0;
    localparam logic [1:0] PAT_ONE  = 2'd1;
    localparam logic [1:0] PAT_TWO  = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    localparam logic REG_LANE_COUNT = 1'b0;
    localparam logic REG_START_RATE = 1'b1;

    localparam logic [1:0] LEVEL_MAX = 2'd3;

    // status nibble bits
    localparam int ST_CR_DONE  = 0;
    localparam int ST_EQ_DONE  = 1;
    localparam int ST_SYM_LOCK = 2;

    localparam logic [2:0] CNT_MAX = 3'd7;

    typedef logic [5:0] drive_t;
    typedef logic [2:0] count_t;

    typedef struct packed {
        drive_t drive;      // drive setting from this request
        count_t count;      // request counter after this step
        logic   same;       // request equals current drive
        logic   hit_limit;  // repeated-request limit reached
        logic   max_req;    // max swing or max pre-emphasis requested
        logic   mismatch;   // status differs from lane 0
    } lane_res_t;

endpackage
`default_nettype wire

// ===== design/dpltc_lane.sv =====
`default_nettype none
module dpltc_lane #(
    parameter int CR_LOOP_LIMIT = 5
) (
    input  wire logic [3:0]          req,
    input  wire logic [3:0]          stat,
    input  wire logic [3:0]          stat0,
    input  wire logic                active,
    input  wire dpltc_pkg::drive_t   drive_cur,
    input  wire dpltc_pkg::count_t   count_cur,
    output dpltc_pkg::lane_res_t     res
);

    logic [1:0] swing;
    logic [1:0] emph;

    assign swing = req[1:0];
    assign emph  = req[3:2];

    always_comb
    begin
        res.drive    = {emph == dpltc_pkg::LEVEL_MAX, emph,
                        swing == dpltc_pkg::LEVEL_MAX, swing};
        res.same     = (drive_cur[1:0] == swing) && (drive_cur[4:3] == emph);
        res.max_req  = active && ((swing == dpltc_pkg::LEVEL_MAX) ||
                                  (emph == dpltc_pkg::LEVEL_MAX));
        res.mismatch = active && (stat != stat0);
        res.count    = count_cur;
        if (res.same && (count_cur != dpltc_pkg::CNT_MAX))
        begin
            res.count = count_cur + 3'd1;
        end
        res.hit_limit = active && res.same && (res.count == 3'(CR_LOOP_LIMIT));
    end

endmodule
`default_nettype wire

// ===== design/dp_link_training_controller.sv =====
`default_nettype none
`include "dp_link_training_controller_macros.svh"
// DisplayPort source link training controller. Each start or poll item is
// evaluated combinationally: four lane slices check status and requests
// in parallel, a merge stage decides the phase, and the result lands in one
// output register. An item can be accepted every cycle while results are
// taken, including in the cycle the previous result is taken; a result that
// waits holds off the next item. out_valid rises in the cycle after accept.
// The user must write lane_count and start_rate_high through cfg_we,
// cfg_index and cfg_wdata only while idle; the block does not enforce this.
module dp_link_training_controller #(
    parameter int CR_LOOP_LIMIT = 5,
    parameter int EQ_LOOP_LIMIT = 5,
    parameter int MAX_LANES     = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [2:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       op,
    input  wire logic [7:0] lane01_status,
    input  wire logic [7:0] lane23_status,
    input  wire logic [7:0] align_status,
    input  wire logic [7:0] adjust_req01,
    input  wire logic [7:0] adjust_req23,
    input  wire logic       aux_ok,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      phase,
    output logic [1:0]      training_pattern,
    output logic            link_rate_high,
    output logic [5:0]      lane0_set,
    output logic [5:0]      lane1_set,
    output logic [5:0]      lane2_set,
    output logic [5:0]      lane3_set
);

    localparam int NL = 4;

    logic [2:0] lane_count_reg;
    logic       start_rate_reg;

    logic [2:0]         phase_reg, phase_next;
    logic               rate_reg, rate_next;
    dpltc_pkg::count_t  eq_count_reg, eq_count_next;
    dpltc_pkg::count_t  req_count_reg [NL];
    dpltc_pkg::count_t  req_count_next [NL];
    dpltc_pkg::drive_t  drive_reg [NL];
    dpltc_pkg::drive_t  drive_next [NL];

    logic               out_valid_reg;
    logic [2:0]         out_phase_reg;
    logic [1:0]         out_pattern_reg;
    logic               out_rate_reg;
    dpltc_pkg::drive_t  out_set_reg [NL];

    logic [3:0]           req_nib [NL];
    logic [3:0]           st_nib [NL];
    logic [NL-1:0]        active;
    logic [2:0]           n_lanes;
    dpltc_pkg::lane_res_t lane_res [NL];

    logic               in_fire;
    logic               any_mismatch;
    logic               any_trigger;
    logic               do_reduce;
    logic               do_begin;
    dpltc_pkg::count_t  eq_inc;
    logic [1:0]         pattern_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign req_nib[0] = adjust_req01[3:0];
    assign req_nib[1] = adjust_req01[7:4];
    assign req_nib[2] = adjust_req23[3:0];
    assign req_nib[3] = adjust_req23[7:4];
    assign st_nib[0]  = lane01_status[3:0];
    assign st_nib[1]  = lane01_status[7:4];
    assign st_nib[2]  = lane23_status[3:0];
    assign st_nib[3]  = lane23_status[7:4];

    // clamp lane count to 1..MAX_LANES
    always_comb
    begin
        n_lanes = lane_count_reg;
        if (lane_count_reg == 3'd0)
        begin
            n_lanes = 3'd1;
        end
        else if (lane_count_reg > 3'(MAX_LANES))
        begin
            n_lanes = 3'(MAX_LANES);
        end
    end

    for (genvar g = 0; g < NL; g++)
    begin : g_lane
        assign active[g] = (3'(g) < n_lanes);

        dpltc_lane #(
            .CR_LOOP_LIMIT(CR_LOOP_LIMIT)
        ) u_lane (
            .req       (req_nib[g]),
            .stat      (st_nib[g]),
            .stat0     (st_nib[0]),
            .active    (active[g]),
            .drive_cur (drive_reg[g]),
            .count_cur (req_count_reg[g]),
            .res       (lane_res[g])
        );
    end

    // merge stage
    always_comb
    begin
        any_mismatch  = 1'b0;
        any_trigger   = 1'b0;
        for (int i = 0; i < NL; i++)
        begin
            any_mismatch = any_mismatch | lane_res[i].mismatch;
            any_trigger  = any_trigger | lane_res[i].max_req | lane_res[i].hit_limit;
        end

        eq_inc = eq_count_reg;
        if (eq_count_reg != dpltc_pkg::CNT_MAX)
        begin
            eq_inc = eq_count_reg + 3'd1;
        end

        phase_next    = phase_reg;
        rate_next     = rate_reg;
        eq_count_next = eq_count_reg;
        for (int i = 0; i < NL; i++)
        begin
            req_count_next[i] = req_count_reg[i];
            drive_next[i]     = drive_reg[i];
        end
        do_reduce = 1'b0;
        do_begin  = 1'b0;

        if (op == dpltc_pkg::OP_START)
        begin
            rate_next = start_rate_reg;
            do_begin  = 1'b1;
        end
        else if ((phase_reg == dpltc_pkg::PH_CR) || (phase_reg == dpltc_pkg::PH_EQ))
        begin
            if (!aux_ok || any_mismatch)
            begin
                phase_next = dpltc_pkg::PH_FAIL;
            end
            else if (phase_reg == dpltc_pkg::PH_CR)
            begin
                for (int i = 0; i < NL; i++)
                begin
                    if (active[i])
                    begin
                        drive_next[i] = lane_res[i].drive;
                        if (!st_nib[0][dpltc_pkg::ST_CR_DONE])
                        begin
                            req_count_next[i] = lane_res[i].count;
                        end
                    end
                end
                if (st_nib[0][dpltc_pkg::ST_CR_DONE])
                begin
                    phase_next = dpltc_pkg::PH_EQ;
                end
                else
                begin
                    do_reduce = any_trigger;
                end
            end
            else if (st_nib[0][dpltc_pkg::ST_CR_DONE])
            begin
                if (st_nib[0][dpltc_pkg::ST_EQ_DONE] && st_nib[0][dpltc_pkg::ST_SYM_LOCK]
                    && align_status[0])
                begin
                    phase_next = dpltc_pkg::PH_DONE;
                end
                else
                begin
                    eq_count_next = eq_inc;
                    if (eq_inc > 3'(EQ_LOOP_LIMIT))
                    begin
                        do_reduce = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < NL; i++)
                        begin
                            if (active[i])
                            begin
                                drive_next[i] = lane_res[i].drive;
                            end
                        end
                    end
                end
            end
            else
            begin
                do_reduce = 1'b1;
            end
        end

        // one rate reduction per step at most
        if (do_reduce)
        begin
            if (rate_reg)
            begin
                rate_next = 1'b0;
                do_begin  = 1'b1;
            end
            else
            begin
                phase_next = dpltc_pkg::PH_FAIL;
            end
        end

        if (do_begin)
        begin
            phase_next    = dpltc_pkg::PH_CR;
            eq_count_next = '0;
            for (int i = 0; i < NL; i++)
            begin
                req_count_next[i] = '0;
                drive_next[i]     = '0;
            end
        end

        if ((op == dpltc_pkg::OP_START) && !aux_ok)
        begin
            phase_next = dpltc_pkg::PH_FAIL;
        end

        pattern_next = dpltc_pkg::PAT_NONE;
        if (phase_next == dpltc_pkg::PH_CR)
        begin
            pattern_next = dpltc_pkg::PAT_ONE;
        end
        else if (phase_next == dpltc_pkg::PH_EQ)
        begin
            pattern_next = dpltc_pkg::PAT_TWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_count_reg <= 3'd4;
            start_rate_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dpltc_pkg::REG_LANE_COUNT: lane_count_reg <= cfg_wdata;
                dpltc_pkg::REG_START_RATE: start_rate_reg <= cfg_wdata[0];
                default:                   lane_count_reg <= lane_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= dpltc_pkg::PH_IDLE;
            rate_reg     <= 1'b1;
            eq_count_reg <= '0;
            for (int i = 0; i < NL; i++)
            begin
                req_count_reg[i] <= '0;
                drive_reg[i]     <= '0;
            end
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            rate_reg     <= rate_next;
            eq_count_reg <= eq_count_next;
            for (int i = 0; i < NL; i++)
            begin
                req_count_reg[i] <= req_count_next[i];
                drive_reg[i]     <= drive_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_phase_reg   <= phase_next;
            out_pattern_reg <= pattern_next;
            out_rate_reg    <= rate_next;
            for (int i = 0; i < NL; i++)
            begin
                out_set_reg[i] <= active[i] ? drive_next[i] : '0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign phase            = out_phase_reg;
    assign training_pattern = out_pattern_reg;
    assign link_rate_high   = out_rate_reg;
    assign lane0_set        = out_set_reg[0];
    assign lane1_set        = out_set_reg[1];
    assign lane2_set        = out_set_reg[2];
    assign lane3_set        = out_set_reg[3];

    `DPLTC_ASSERT_NEXT(a_start_fail, clk, rst_n,
        in_fire && (op == dpltc_pkg::OP_START) && !aux_ok,
        out_valid && (phase == dpltc_pkg::PH_FAIL) && (phase_reg == dpltc_pkg::PH_FAIL))
    `DPLTC_ASSERT_NEXT(a_start_cr, clk, rst_n,
        in_fire && (op == dpltc_pkg::OP_START) && aux_ok,
        (phase_reg == dpltc_pkg::PH_CR) && (eq_count_reg == 3'd0) && (drive_reg[0] == 6'd0))
    `DPLTC_ASSERT_NEXT(a_done_sticky, clk, rst_n,
        in_fire && (op == dpltc_pkg::OP_POLL) && (phase_reg == dpltc_pkg::PH_DONE),
        phase_reg == dpltc_pkg::PH_DONE)
    `DPLTC_ASSERT_NOW(a_pattern_phase, clk, rst_n,
        out_valid,
        (training_pattern == dpltc_pkg::PAT_ONE) == (phase == dpltc_pkg::PH_CR))

endmodule
`default_nettype wire

// ===== tb/tb_dp_link_training_controller.sv =====
`timescale 1ns / 100ps

import dpltc_pkg::*;

typedef struct packed {
    logic       op;
    logic [7:0] st01;
    logic [7:0] st23;
    logic [7:0] align;
    logic [7:0] req01;
    logic [7:0] req23;
    logic       aux;
} poll_t;

typedef struct packed {
    logic [2:0]       ph;
    logic [1:0]       pat;
    logic             rate;
    drive_t [3:0]     lanes;
} report_t;

class link_train_scoreboard;
    localparam int CR_LIMIT   = 5;
    localparam int EQ_LIMIT   = 5;
    localparam int LANES_MAX  = 4;

    logic [2:0] lanes_cfg;
    logic       start_hi;
    logic [2:0] ph;
    logic       rate_hi;
    count_t     rep_cnt [4];
    count_t     eq_cnt;
    drive_t     drv [4];
    report_t    due_q [$];
    int         errors;

    function new();
        lanes_cfg = 3'd4;
        start_hi  = 1'b1;
        rate_hi   = 1'b1;
        ph        = PH_IDLE;
        errors    = 0;
        restart();
        ph = PH_IDLE;
    endfunction

    function void write_reg(logic idx, logic [2:0] val);
        if (idx == REG_LANE_COUNT)
            lanes_cfg = val;
        else
            start_hi = val[0];
    endfunction

    function int active_lanes();
        int n;
        n = lanes_cfg;
        if (n < 1)
            n = 1;
        if (n > LANES_MAX)
            n = LANES_MAX;
        return n;
    endfunction

    // lanes 0/1 come from the low byte, odd lanes from the high nibble
    function logic [3:0] nib(int lane, logic [7:0] lo, logic [7:0] hi);
        logic [7:0] b;
        b = (lane < 2) ? lo : hi;
        return lane[0] ? b[7:4] : b[3:0];
    endfunction

    function drive_t to_drive(logic [3:0] r);
        drive_t d;
        d = {1'b0, r[3:2], 1'b0, r[1:0]};
        if (r[1:0] == LEVEL_MAX)
            d[2] = 1'b1;
        if (r[3:2] == LEVEL_MAX)
            d[5] = 1'b1;
        return d;
    endfunction

    function void restart();
        ph     = PH_CR;
        eq_cnt = '0;
        for (int i = 0; i < 4; i++)
        begin
            rep_cnt[i] = '0;
            drv[i]     = '0;
        end
    endfunction

    function void drop_rate();
        if (rate_hi)
        begin
            rate_hi = 1'b0;
            restart();
        end
        else
            ph = PH_FAIL;
    endfunction

    function void note_input(poll_t it);
        int         n;
        logic [3:0] req [4];
        logic [3:0] st0;
        logic [1:0] sw;
        logic [1:0] em;
        bit         same_st;
        bit         trig;
        report_t    r;
        n       = active_lanes();
        same_st = 1'b1;
        trig    = 1'b0;
        for (int i = 0; i < 4; i++)
            req[i] = nib(i, it.req01, it.req23);
        if (it.op == OP_START)
        begin
            rate_hi = start_hi;
            restart();
            if (!it.aux)
                ph = PH_FAIL;
        end
        else if (ph == PH_CR || ph == PH_EQ)
        begin
            st0 = nib(0, it.st01, it.st23);
            for (int i = 0; i < n; i++)
                if (nib(i, it.st01, it.st23) != st0)
                    same_st = 1'b0;
            if (!it.aux || !same_st)
                ph = PH_FAIL;
            else if (ph == PH_CR)
            begin
                if (st0[ST_CR_DONE])
                begin
                    for (int i = 0; i < n; i++)
                        drv[i] = to_drive(req[i]);
                    ph = PH_EQ;
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        sw = req[i][1:0];
                        em = req[i][3:2];
                        if (sw == LEVEL_MAX || em == LEVEL_MAX)
                            trig = 1'b1;
                        if (drv[i][1:0] == sw && drv[i][4:3] == em)
                        begin
                            if (rep_cnt[i] != CNT_MAX)
                                rep_cnt[i]++;
                            if (rep_cnt[i] == CR_LIMIT)
                                trig = 1'b1;
                        end
                        drv[i] = to_drive(req[i]);
                    end
                    if (trig)
                        drop_rate();
                end
            end
            else if (st0[ST_CR_DONE])
            begin
                if (st0[ST_EQ_DONE] && st0[ST_SYM_LOCK] && it.align[0])
                    ph = PH_DONE;
                else
                begin
                    if (eq_cnt != CNT_MAX)
                        eq_cnt++;
                    if (eq_cnt > EQ_LIMIT)
                        drop_rate();
                    else
                        for (int i = 0; i < n; i++)
                            drv[i] = to_drive(req[i]);
                end
            end
            else
                drop_rate();
        end
        r.ph   = ph;
        r.pat  = (ph == PH_CR) ? PAT_ONE : ((ph == PH_EQ) ? PAT_TWO : PAT_NONE);
        r.rate = rate_hi;
        for (int i = 0; i < 4; i++)
            r.lanes[i] = (i < n) ? drv[i] : '0;
        due_q.push_back(r);
    endfunction

    function void cmp_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    function void check_result(report_t got);
        report_t want;
        if (due_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got %0h", $time, got);
            errors++;
            return;
        end
        want = due_q.pop_front();
        cmp_field("phase", 8'(want.ph), 8'(got.ph));
        cmp_field("training_pattern", 8'(want.pat), 8'(got.pat));
        cmp_field("link_rate_high", 8'(want.rate), 8'(got.rate));
        for (int i = 0; i < 4; i++)
            cmp_field($sformatf("lane%0d_set", i), 8'(want.lanes[i]), 8'(got.lanes[i]));
    endfunction

    function int pending();
        return due_q.size();
    endfunction
endclass

module tb_dp_link_training_controller;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_SETTING = 170;

    typedef enum int {MODE_NORMAL, MODE_EQ_STUCK, MODE_CR_STUCK, MODE_NOISE} sink_mode_e;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = REG_LANE_COUNT;
    logic [2:0] cfg_wdata = 3'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       op = OP_START;
    logic [7:0] lane01_status = 8'd0;
    logic [7:0] lane23_status = 8'd0;
    logic [7:0] align_status = 8'd0;
    logic [7:0] adjust_req01 = 8'd0;
    logic [7:0] adjust_req23 = 8'd0;
    logic       aux_ok = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b1;
    logic [2:0] phase;
    logic [1:0] training_pattern;
    logic       link_rate_high;
    logic [5:0] lane0_set;
    logic [5:0] lane1_set;
    logic [5:0] lane2_set;
    logic [5:0] lane3_set;

    link_train_scoreboard sb = new();

    int  cycles = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;
    int  stall_left = 0;
    int  lane_sweep [10] = '{4, 1, 2, 4, 3, 0, 7, 2, 1, 4};
    int  rate_sweep [10] = '{1, 1, 0, 0, 1, 1, 0, 1, 0, 1};

    dp_link_training_controller u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .lane01_status    (lane01_status),
        .lane23_status    (lane23_status),
        .align_status     (align_status),
        .adjust_req01     (adjust_req01),
        .adjust_req23     (adjust_req23),
        .aux_ok           (aux_ok),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .phase            (phase),
        .training_pattern (training_pattern),
        .link_rate_high   (link_rate_high),
        .lane0_set        (lane0_set),
        .lane1_set        (lane1_set),
        .lane2_set        (lane2_set),
        .lane3_set        (lane3_set)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check, then draw the stall before the next result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result({phase, training_pattern, link_rate_high,
                             lane3_set, lane2_set, lane1_set, lane0_set});
            if ($urandom_range(0, 15) == 0)
                recv_calm = !recv_calm;
            stall_left = recv_calm ? 0 : $urandom_range(0, 3);
            if (stall_left != 0)
                out_ready <= 1'b0;
        end
        else if (!out_ready)
        begin
            if (stall_left > 1)
                stall_left--;
            else
            begin
                stall_left = 0;
                out_ready <= 1'b1;
            end
        end
    end

    function automatic poll_t mk(logic o, logic [7:0] s01, logic [7:0] s23, logic [7:0] al,
                                 logic [7:0] r01, logic [7:0] r23, logic ax);
        poll_t it;
        it = '{op: o, st01: s01, st23: s23, align: al, req01: r01, req23: r23, aux: ax};
        return it;
    endfunction

    function automatic poll_t start_item();
        return mk(OP_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), $urandom_range(0, 19) != 0);
    endfunction

    function automatic sink_mode_e pick_mode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return MODE_NORMAL;
        if (roll < 70)
            return MODE_EQ_STUCK;
        if (roll < 90)
            return MODE_CR_STUCK;
        return MODE_NOISE;
    endfunction

    // Sink answer shaped by the predicted phase so training gets deep.
    function automatic poll_t rand_poll(sink_mode_e mode);
        poll_t       it;
        logic [3:0]  s;
        logic [3:0]  r [4];
        logic [15:0] flip;
        bit          done;
        int          pick;
        it = mk(OP_POLL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), $urandom_range(0, 99) >= 3);
        if (mode == MODE_NOISE)
        begin
            it.op  = 1'($urandom);
            it.aux = 1'($urandom);
            return it;
        end
        if (sb.ph != PH_CR && sb.ph != PH_EQ)
            return it;
        s = 4'($urandom);
        if (sb.ph == PH_CR)
        begin
            done = (mode != MODE_CR_STUCK) && ($urandom_range(0, 99) < 25);
            s[ST_CR_DONE] = done;
            for (int i = 0; i < 4; i++)
            begin
                if (done)
                    r[i] = 4'($urandom);
                else if (mode == MODE_CR_STUCK || $urandom_range(0, 99) < 40)
                    r[i] = {sb.drv[i][4:3], sb.drv[i][1:0]};
                else if ($urandom_range(0, 99) < 90)
                    r[i] = {2'($urandom_range(0, 2)), 2'($urandom_range(0, 2))};
                else
                    r[i] = 4'($urandom);
            end
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (mode != MODE_EQ_STUCK && pick < 35)
            begin
                s[2:0] = 3'b111;
                it.align[0] = ($urandom_range(0, 9) != 0);
            end
            else if (mode == MODE_EQ_STUCK || pick < 90)
            begin
                s[ST_CR_DONE] = 1'b1;
                if (s[ST_EQ_DONE] && s[ST_SYM_LOCK])
                    it.align[0] = 1'b0;
            end
            else
                s[ST_CR_DONE] = 1'b0;
            for (int i = 0; i < 4; i++)
                r[i] = 4'($urandom);
        end
        flip = '0;
        if ($urandom_range(0, 99) < 4)
            flip = 16'(1) << $urandom_range(0, 15);
        it.st01  = {s, s} ^ flip[7:0];
        it.st23  = {s, s} ^ flip[15:8];
        it.req01 = {r[1], r[0]};
        it.req23 = {r[3], r[2]};
        return it;
    endfunction

    // called at a rising edge; returns at the edge the item is taken or after its gap
    task automatic push_item(poll_t it);
        int gap;
        op            <= it.op;
        lane01_status <= it.st01;
        lane23_status <= it.st23;
        align_status  <= it.align;
        adjust_req01  <= it.req01;
        adjust_req23  <= it.req23;
        aux_ok        <= it.aux;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(it);
        if ($urandom_range(0, 15) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [2:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    initial
    begin
        int         taken;
        bit         training;
        poll_t      it;
        sink_mode_e mode;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: four lanes, start at the high rate
        push_item(mk(OP_POLL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));  // idle, ignored
        push_item(mk(OP_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        push_item(mk(OP_POLL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        push_item(mk(OP_POLL, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1));  // max req: drop rate
        push_item(mk(OP_POLL, 8'h00, 8'h00, 8'h00, 8'h33, 8'h33, 1'b1));  // already low: fail
        push_item(mk(OP_POLL, 8'h11, 8'h11, 8'h01, 8'h00, 8'h00, 1'b1));  // failed, ignored
        push_item(mk(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)); // sideband error
        push_item(mk(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        push_item(mk(OP_POLL, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));  // lane status differs
        push_item(mk(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        repeat (5)  // same request until the loop limit
            push_item(mk(OP_POLL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        push_item(mk(OP_POLL, 8'h11, 8'h11, 8'h00, 8'h5A, 8'hA5, 1'b1));
        push_item(mk(OP_POLL, 8'h33, 8'h33, 8'h00, 8'h96, 8'h69, 1'b1));
        push_item(mk(OP_POLL, 8'h77, 8'h77, 8'hFE, 8'hC3, 8'h3C, 1'b1));
        push_item(mk(OP_POLL, 8'h77, 8'h77, 8'h01, 8'h00, 8'h00, 1'b1));
        push_item(mk(OP_POLL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));  // finished, ignored
        push_item(mk(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        push_item(mk(OP_POLL, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1));  // to eq, max flags
        push_item(mk(OP_POLL, 8'hEE, 8'hEE, 8'h00, 8'h00, 8'h00, 1'b1));  // lost clock recovery
        push_item(mk(OP_POLL, 8'h11, 8'h11, 8'h00, 8'h00, 8'h00, 1'b0));
        drain();

        for (int k = 0; k < 10; k++)
        begin
            write_reg(REG_LANE_COUNT, 3'(lane_sweep[k]));
            write_reg(REG_START_RATE, 3'(rate_sweep[k]));
            mode  = pick_mode();
            taken = 0;
            while (taken < ITEMS_PER_SETTING)
            begin
                training = (sb.ph == PH_CR) || (sb.ph == PH_EQ);
                if (training ? ($urandom_range(0, 99) < 3) : ($urandom_range(0, 3) != 0))
                begin
                    it   = start_item();
                    mode = pick_mode();
                end
                else
                    it = rand_poll(mode);
                if (training || it.op == OP_START)
                    taken++;
                push_item(it);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
